/* rtl/core/mtx_pkg.sv */
// mutex table package: widths, request and status codes, records, controller states
package mtx_pkg;

    // default table sizes
    localparam int NUM_MUTEXES_DEF = 32;
    localparam int NUM_TASKS_DEF   = 64;

    // payload field widths
    localparam int FUNC_W   = 2;
    localparam int MID_W    = 8;
    localparam int TASK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int HANDLE_W = 5;

    // request kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_LOCK   = 2'd1,
        FUNC_UNLOCK = 2'd2
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DEADLOCK  = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_NONE_FREE = 3'd4
    } t_status;

    // per-mutex record held in the mutex memory
    typedef struct packed {
        logic              locked;
        logic [TASK_W-1:0] owner;
        logic              qne;
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } t_mutex_rec;

    localparam int MREC_W = $bits(t_mutex_rec);

    // per-task successor link held in the link memory
    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] task_id;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    // one result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                granted;
        logic                wake_valid;
        logic [TASK_W-1:0]   wake_task;
    } t_result;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_CLR,
        S_RESP
    } t_state;

endpackage

/* rtl/core/mtx_if.sv */
// request and response channel interfaces of the mutex table
interface mtx_req_if;
    import mtx_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [MID_W-1:0]  mutex_id;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output func, output mutex_id, output task_id, input ready);
    modport sink   (input valid, input func, input mutex_id, input task_id, output ready);
endinterface

interface mtx_rsp_if;
    import mtx_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] new_handle;
    logic                granted;
    logic                wake_valid;
    logic [TASK_W-1:0]   wake_task;

    modport source (output valid, output status, output new_handle, output granted,
                    output wake_valid, output wake_task, input ready);
    modport sink   (input valid, input status, input new_handle, input granted,
                    input wake_valid, input wake_task, output ready);
endinterface

/* rtl/core/mtx_ram.sv */
// generic single-write, single-read memory with registered read data
module mtx_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mtx_free_enc.sv */
// lowest-free-entry priority encoder over the allocated bits
module mtx_free_enc #(
    parameter int N = 32,
    parameter int W = 5
) (
    input  logic [N-1:0] i_alloc,
    output logic         o_found,
    output logic [W-1:0] o_idx
);

    // scan from the top so the lowest free entry wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!i_alloc[i]) begin
                o_found = 1'b1;
                o_idx   = W'(i);
            end
        end
    end

endmodule

/* rtl/core/mutex_table_with_fifo_waiters.sv */
// mutex table top level: request sequencer over the mutex and link memories
//
//  channel | dir | payload                                         | transaction
//  i_req   | in  | func, mutex_id, task_id                         | valid & ready
//  o_rsp   | out | status, new_handle, granted, wake_valid, wake_task | valid & ready
//
// a request passes through accept and mutex read, execute and response load; an unlock
// that hands over to a waiter adds a link memory read state, and a queued lock adds a second
// link write state; the link read latency and the single link write port force these added states.
// a new request is taken once the previous one has moved to the output register.
// reset clears the state, the output valid and the allocated bits; a create rewrites its record, so the
// memories need no clearing pass. a stalled output holds the sequencer in response.
module mutex_table_with_fifo_waiters #(
    parameter int NUM_MUTEXES = mtx_pkg::NUM_MUTEXES_DEF,
    parameter int NUM_TASKS   = mtx_pkg::NUM_TASKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mtx_req_if.sink        i_req,
    mtx_rsp_if.source      o_rsp
);
    import mtx_pkg::*;

    localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func;
    logic [MID_W-1:0]    r_mid;
    logic [TASK_W-1:0]   r_task;
    logic [NUM_MUTEXES-1:0] r_alloc, n_alloc;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // memory ports
    logic                mram_re, mram_we;
    logic [MW-1:0]       mram_waddr;
    t_mutex_rec          mram_wdata;
    logic [MREC_W-1:0]   mram_rdata;
    t_mutex_rec          mrec;
    logic                lram_re, lram_we;
    logic [TW-1:0]       lram_waddr;
    t_link               lram_wdata;
    logic [LINK_W-1:0]   lram_rdata;
    t_link               link;

    // decode
    logic                free_found;
    logic [MW-1:0]       free_idx;
    logic                is_create, is_lock, is_unlock;
    logic                mid_ok, task_ok, target_ok, holder;
    logic                lock_dead, lock_queue, lock_grant;
    logic                unl_bad, unl_free, unl_hand;
    logic                out_free;

    mtx_ram #(.WIDTH(MREC_W), .DEPTH(NUM_MUTEXES)) u_mutex_ram (
        .i_clk   (i_clk),
        .i_we    (mram_we),
        .i_waddr (mram_waddr),
        .i_wdata (mram_wdata),
        .i_re    (mram_re),
        .i_raddr (i_req.mutex_id[MW-1:0]),
        .o_rdata (mram_rdata)
    );

    mtx_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TASKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lram_we),
        .i_waddr (lram_waddr),
        .i_wdata (lram_wdata),
        .i_re    (lram_re),
        .i_raddr (TW'(mrec.head)),
        .o_rdata (lram_rdata)
    );

    mtx_free_enc #(.N(NUM_MUTEXES), .W(MW)) u_free_enc (
        .i_alloc (r_alloc),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    assign mrec = t_mutex_rec'(mram_rdata);
    assign link = t_link'(lram_rdata);

    // request classification from the captured request and the mutex record
    assign is_create  = (r_func == FUNC_CREATE);
    assign is_lock    = (r_func == FUNC_LOCK);
    assign is_unlock  = (r_func == FUNC_UNLOCK);
    assign mid_ok     = ({1'b0, r_mid} < 9'(NUM_MUTEXES));
    assign task_ok    = ({3'b000, r_task} < 9'(NUM_TASKS));
    assign target_ok  = (is_lock || is_unlock) && mid_ok && task_ok && r_alloc[r_mid[MW-1:0]];
    assign holder     = mrec.locked && (mrec.owner == r_task);
    assign lock_dead  = is_lock && target_ok && holder;
    assign lock_queue = is_lock && target_ok && mrec.locked && !holder;
    assign lock_grant = is_lock && target_ok && !mrec.locked;
    assign unl_bad    = is_unlock && target_ok && !holder;
    assign unl_free   = is_unlock && target_ok && holder && !mrec.qne;
    assign unl_hand   = is_unlock && target_ok && holder && mrec.qne;

    assign out_free   = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (unl_hand) begin
                    n_state = S_LINK;
                end else if (lock_queue) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_LINK:  n_state = S_RESP;
            S_CLR:   n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and result staging
    always_comb begin
        i_req.ready = 1'b0;
        mram_re     = 1'b0;
        mram_we     = 1'b0;
        mram_waddr  = r_mid[MW-1:0];
        mram_wdata  = mrec;
        lram_re     = 1'b0;
        lram_we     = 1'b0;
        lram_waddr  = TW'(mrec.tail);
        lram_wdata  = '{valid: 1'b1, task_id: r_task};
        n_alloc     = r_alloc;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                i_req.ready = i_rst_n;
                mram_re     = i_req.valid && i_rst_n;
            end
            S_EXEC: begin
                lram_re = 1'b1;
                n_res   = '{status: ST_INVALID, default: '0};
                if (is_create) begin
                    if (free_found) begin
                        n_alloc[free_idx] = 1'b1;
                        mram_we      = 1'b1;
                        mram_waddr   = free_idx;
                        mram_wdata   = '0;
                        n_res.status = ST_OK;
                        n_res.handle = HANDLE_W'(free_idx);
                    end else begin
                        n_res.status = ST_NONE_FREE;
                    end
                end else if (lock_dead) begin
                    n_res.status = ST_DEADLOCK;
                end else if (lock_queue) begin
                    // append at the tail; the caller's own link is cleared next cycle
                    mram_we         = 1'b1;
                    mram_wdata.qne  = 1'b1;
                    mram_wdata.tail = r_task;
                    if (!mrec.qne) begin
                        mram_wdata.head = r_task;
                    end
                    lram_we      = mrec.qne;
                    n_res.status = ST_OK;
                end else if (lock_grant) begin
                    mram_we          = 1'b1;
                    mram_wdata.locked = 1'b1;
                    mram_wdata.owner = r_task;
                    mram_wdata.qne   = 1'b0;
                    n_res.status     = ST_OK;
                    n_res.granted    = 1'b1;
                end else if (unl_bad) begin
                    n_res.status = ST_NOT_OWNER;
                end else if (unl_free) begin
                    mram_we           = 1'b1;
                    mram_wdata.locked = 1'b0;
                    mram_wdata.owner  = '0;
                    n_res.status      = ST_OK;
                end else if (unl_hand) begin
                    n_res.status     = ST_OK;
                    n_res.wake_valid = 1'b1;
                    n_res.wake_task  = mrec.head;
                end
            end
            S_LINK: begin
                // hand the mutex to the oldest waiter and pop it
                mram_we          = 1'b1;
                mram_wdata.owner = mrec.head;
                if (link.valid) begin
                    mram_wdata.head = link.task_id;
                end else begin
                    mram_wdata.qne = 1'b0;
                end
            end
            S_CLR: begin
                lram_we    = 1'b1;
                lram_waddr = TW'(r_task);
                lram_wdata = '0;
            end
            S_RESP: begin
                n_res = r_res;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_state == S_RESP && out_free) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_alloc     <= n_alloc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_func <= i_req.func;
            r_mid  <= i_req.mutex_id;
            r_task <= i_req.task_id;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.new_handle = r_out.handle;
    assign o_rsp.granted    = r_out.granted;
    assign o_rsp.wake_valid = r_out.wake_valid;
    assign o_rsp.wake_task  = r_out.wake_task;

`ifndef SYNTH
    // a response only appears when the sequencer is loading one
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("response raised outside response state");

    // mutexes are never freed once created
    a_alloc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_alloc & $past(r_alloc)) == $past(r_alloc)))
        else $error("allocated bit cleared");

    // mutex records are written only while executing or handing over
    a_mram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mram_we |-> (r_state == S_EXEC || r_state == S_LINK))
        else $error("mutex memory written in wrong state");

    // a handover is a plain success without an immediate grant
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.wake_valid) |-> (o_rsp.status == ST_OK && !o_rsp.granted))
        else $error("wake with bad status");
`endif

endmodule

/* dv/mutex_table_with_fifo_waiters_tb.sv */
// testbench for the mutex table: directed and random request stream checked against a local table model
`timescale 1ns / 100ps

module mutex_table_with_fifo_waiters_tb;
    import mtx_pkg::*;

    localparam int NUM_MUTEXES = NUM_MUTEXES_DEF;
    localparam int NUM_TASKS   = NUM_TASKS_DEF;
    localparam int RANDOM_REQS = 600;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 12;

    // request kind outside the defined set
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    // table copies: 0 tracks the stimulus generator, 1 tracks accepted requests
    localparam int GEN_VIEW = 0;
    localparam int CHK_VIEW = 1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MID_W-1:0]  mutex_id;
        logic [TASK_W-1:0] task_id;
    } t_req_item;

    logic i_clk;
    logic i_rst_n;

    mtx_req_if req_if ();
    mtx_rsp_if rsp_if ();

    mutex_table_with_fifo_waiters DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // mutex table contents, one copy per view
    bit                alloc_m [2][NUM_MUTEXES];
    bit                lock_m  [2][NUM_MUTEXES];
    logic [TASK_W-1:0] owner_m [2][NUM_MUTEXES];
    bit                qne_m   [2][NUM_MUTEXES];
    logic [TASK_W-1:0] head_m  [2][NUM_MUTEXES];
    logic [TASK_W-1:0] tail_m  [2][NUM_MUTEXES];
    logic [TASK_W:0]   link_t  [2][NUM_TASKS];

    t_req_item pending_reqs[$];
    t_result   awaited_rsps[$];

    int n_total;
    int n_accepted;
    int n_responses;
    int n_errors;
    int n_grants, n_handovers, n_deadlock, n_not_owner, n_invalid, n_full;
    int req_gap;
    int rsp_stall;
    int idle_cycles;

    // applies one request to a table copy and returns its response
    function automatic t_result serve_request(input int s, input t_req_item it);
        t_result         r;
        int              m;
        bit              found;
        logic [TASK_W:0] lnk;
        r = '0;
        if (it.func == FUNC_CREATE) begin
            r.status = ST_NONE_FREE;
            found = 1'b0;
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                if (!found && !alloc_m[s][i]) begin
                    alloc_m[s][i] = 1'b1;
                    r.status = ST_OK;
                    r.handle = i[HANDLE_W-1:0];
                    found = 1'b1;
                end
            end
            return r;
        end
        r.status = ST_INVALID;
        if (it.func == FUNC_RSVD || int'(it.mutex_id) >= NUM_MUTEXES ||
            int'(it.task_id) >= NUM_TASKS)
            return r;
        m = int'(it.mutex_id);
        if (!alloc_m[s][m])
            return r;
        if (it.func == FUNC_LOCK) begin
            if (lock_m[s][m] && owner_m[s][m] == it.task_id) begin
                r.status = ST_DEADLOCK;
                return r;
            end
            r.status = ST_OK;
            if (lock_m[s][m]) begin
                // held: append caller to the wait list
                if (qne_m[s][m]) begin
                    link_t[s][tail_m[s][m]] = {1'b1, it.task_id};
                end else begin
                    qne_m[s][m]  = 1'b1;
                    head_m[s][m] = it.task_id;
                end
                link_t[s][it.task_id] = '0;
                tail_m[s][m] = it.task_id;
                return r;
            end
            lock_m[s][m]  = 1'b1;
            owner_m[s][m] = it.task_id;
            qne_m[s][m]   = 1'b0;
            r.granted     = 1'b1;
            return r;
        end
        // unlock
        if (!lock_m[s][m] || owner_m[s][m] != it.task_id) begin
            r.status = ST_NOT_OWNER;
            return r;
        end
        r.status = ST_OK;
        if (!qne_m[s][m]) begin
            lock_m[s][m]  = 1'b0;
            owner_m[s][m] = '0;
            return r;
        end
        // hand over to the oldest waiter
        lnk = link_t[s][head_m[s][m]];
        owner_m[s][m] = head_m[s][m];
        r.wake_valid  = 1'b1;
        r.wake_task   = head_m[s][m];
        if (lnk[TASK_W])
            head_m[s][m] = lnk[TASK_W-1:0];
        else
            qne_m[s][m] = 1'b0;
        return r;
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic add_req(input logic [FUNC_W-1:0] f, input logic [MID_W-1:0] mid,
                           input logic [TASK_W-1:0] tid);
        t_req_item it;
        t_result   unused;
        it.func     = f;
        it.mutex_id = mid;
        it.task_id  = tid;
        unused = serve_request(GEN_VIEW, it);
        pending_reqs.push_back(it);
        n_total++;
    endtask

    task automatic check_rsp(input t_result exp);
        if (rsp_if.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, rsp_if.status);
            n_errors++;
        end
        if (rsp_if.new_handle !== exp.handle) begin
            $error("new_handle: expected %0d, got %0d", exp.handle, rsp_if.new_handle);
            n_errors++;
        end
        if (rsp_if.granted !== exp.granted) begin
            $error("granted: expected %0d, got %0d", exp.granted, rsp_if.granted);
            n_errors++;
        end
        if (rsp_if.wake_valid !== exp.wake_valid) begin
            $error("wake_valid: expected %0d, got %0d", exp.wake_valid, rsp_if.wake_valid);
            n_errors++;
        end
        if (rsp_if.wake_task !== exp.wake_task) begin
            $error("wake_task: expected %0d, got %0d", exp.wake_task, rsp_if.wake_task);
            n_errors++;
        end
    endtask

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // request driver
    always @(posedge i_clk) begin
        t_req_item it;
        logic      nxt_valid;
        nxt_valid = req_if.valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                it.func     = req_if.func;
                it.mutex_id = req_if.mutex_id;
                it.task_id  = req_if.task_id;
                awaited_rsps.push_back(serve_request(CHK_VIEW, it));
                n_accepted++;
                nxt_valid = 1'b0;
                // no idling over some stretches
                req_gap = ((n_accepted % 150) < 30) ? 0 : pick_gap();
            end
            if (!nxt_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (pending_reqs.size() != 0) begin
                    it = pending_reqs.pop_front();
                    req_if.func     <= it.func;
                    req_if.mutex_id <= it.mutex_id;
                    req_if.task_id  <= it.task_id;
                    nxt_valid = 1'b1;
                end
            end
        end
        req_if.valid <= nxt_valid;
    end

    // response monitor and back-pressure
    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_responses++;
                if (awaited_rsps.size() == 0) begin
                    $error("response transaction with nothing outstanding");
                    n_errors++;
                end else begin
                    exp = awaited_rsps.pop_front();
                    check_rsp(exp);
                    case (exp.status)
                        ST_OK: begin
                            if (exp.granted) n_grants++;
                            if (exp.wake_valid) n_handovers++;
                        end
                        ST_DEADLOCK:  n_deadlock++;
                        ST_NOT_OWNER: n_not_owner++;
                        ST_INVALID:   n_invalid++;
                        ST_NONE_FREE: n_full++;
                        default: ;
                    endcase
                end
                rsp_stall = ((n_responses % 130) < 25) ? 0 : pick_gap();
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          r;
        int          cnt;
        int          k;
        int          m;
        logic [TASK_W-1:0] tid;
        logic [FUNC_W-1:0] f;

        req_if.valid    = 1'b0;
        req_if.func     = '0;
        req_if.mutex_id = '0;
        req_if.task_id  = '0;
        rsp_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        n_total = 0; n_accepted = 0; n_responses = 0; n_errors = 0;
        n_grants = 0; n_handovers = 0; n_deadlock = 0;
        n_not_owner = 0; n_invalid = 0; n_full = 0;
        req_gap = 0; rsp_stall = 0; idle_cycles = 0;
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                alloc_m[v][i] = 1'b0;
                lock_m[v][i]  = 1'b0;
                owner_m[v][i] = '0;
                qne_m[v][i]   = 1'b0;
                head_m[v][i]  = '0;
                tail_m[v][i]  = '0;
            end
        end

        // directed: creates, grant, deadlock, queueing, requeue, handovers, errors
        add_req(FUNC_CREATE, 8'h00, 6'h00);
        add_req(FUNC_CREATE, 8'hff, 6'h3f);
        add_req(FUNC_CREATE, 8'h5a, 6'h15);
        add_req(FUNC_LOCK,   8'd0,  6'd0);
        add_req(FUNC_LOCK,   8'd0,  6'd0);
        add_req(FUNC_LOCK,   8'd0,  6'd63);
        add_req(FUNC_LOCK,   8'd0,  6'd5);
        add_req(FUNC_LOCK,   8'd0,  6'd63);
        add_req(FUNC_UNLOCK, 8'd0,  6'd5);
        add_req(FUNC_UNLOCK, 8'd0,  6'd0);
        add_req(FUNC_UNLOCK, 8'd0,  6'd63);
        add_req(FUNC_UNLOCK, 8'd0,  6'd63);
        add_req(FUNC_UNLOCK, 8'd0,  6'd0);
        add_req(FUNC_LOCK,   8'd255, 6'd1);
        add_req(FUNC_UNLOCK, 8'd32, 6'd1);
        add_req(FUNC_LOCK,   8'd31, 6'd1);
        add_req(FUNC_UNLOCK, 8'd31, 6'd1);
        add_req(FUNC_UNLOCK, 8'd2,  6'd2);
        add_req(FUNC_RSVD,   8'haa, 6'h2a);
        add_req(FUNC_RSVD,   8'h55, 6'h15);
        add_req(FUNC_LOCK,   8'd1,  6'd42);
        add_req(FUNC_LOCK,   8'd1,  6'd21);
        add_req(FUNC_UNLOCK, 8'd1,  6'd42);
        add_req(FUNC_UNLOCK, 8'd1,  6'd21);

        // random: mostly lock and unlock on created mutexes by a small set of tasks
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            cnt = 0;
            for (int i = 0; i < NUM_MUTEXES; i++)
                if (alloc_m[GEN_VIEW][i]) cnt++;
            if (r < 8 || cnt == 0) begin
                add_req(FUNC_CREATE, MID_W'($urandom_range(0, 255)),
                        TASK_W'($urandom_range(0, 63)));
            end else if (r < 14) begin
                add_req(FUNC_W'($urandom_range(0, 3)), MID_W'($urandom_range(0, 255)),
                        TASK_W'($urandom_range(0, 63)));
            end else begin
                k = $urandom_range(0, cnt - 1);
                m = 0;
                for (int i = 0; i < NUM_MUTEXES; i++) begin
                    if (alloc_m[GEN_VIEW][i]) begin
                        if (k == 0) m = i;
                        k--;
                    end
                end
                if ($urandom_range(0, 99) < 80)
                    tid = TASK_W'($urandom_range(0, 7));
                else
                    tid = TASK_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < 55) begin
                    f = FUNC_LOCK;
                end else begin
                    f = FUNC_UNLOCK;
                    if (lock_m[GEN_VIEW][m] && $urandom_range(0, 99) < 80)
                        tid = owner_m[GEN_VIEW][m];
                end
                add_req(f, MID_W'(m), tid);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests, %0d responses checked, %0d errors",
                 n_accepted, n_responses, n_errors);
        $display("tb: grants %0d, handovers %0d, deadlocks %0d, not-owner %0d",
                 n_grants, n_handovers, n_deadlock, n_not_owner);
        $display("tb: invalid %0d, full %0d", n_invalid, n_full);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
